// ===== hw/rtl/fbba_pkg.sv =====
// Shared constants, types and microcode table of the free-block bitmap allocator.
package fbba_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = 64;
  localparam int BC_W      = 12;
  localparam int IDX_W     = 12;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int CB        = 8;

  localparam int WB_LOG = $clog2(WORD_BITS);
  localparam int MAP_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CB_LOG = $clog2(CB);
  localparam int CHUNKS = WORD_BITS / CB;
  localparam int CK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int SUM_W  = MAP_AW + WB_LOG + IDX_W;

  localparam logic [BC_W-1:0] BC_RESET = BC_W'(4032);
  localparam logic [BC_W-1:0] LAST_CAP = BC_W'(MAP_WORDS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SEARCH = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_FORMAT = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_SCAN = 3'd1,
    OP_BITS = 3'd2,
    OP_CLR  = 3'd3,
    OP_DONE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    C_DISPATCH = 3'd0,
    C_SCAN     = 3'd1,
    C_BITS     = 3'd2,
    C_ALWAYS   = 3'd3,
    C_OUT      = 3'd4
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_SCAN = 3'd1;
  localparam step_t ST_BITS = 3'd2;
  localparam step_t ST_CLR  = 3'd3;
  localparam step_t ST_DONE = 3'd4;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    step_t alt;
  } uword_t;

  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    case (pc)
      ST_IDLE: w = '{op: OP_IDLE, cond: C_DISPATCH, tgt: ST_IDLE, alt: ST_IDLE};
      ST_SCAN: w = '{op: OP_SCAN, cond: C_SCAN,     tgt: ST_BITS, alt: ST_DONE};
      ST_BITS: w = '{op: OP_BITS, cond: C_BITS,     tgt: ST_DONE, alt: ST_DONE};
      ST_CLR:  w = '{op: OP_CLR,  cond: C_ALWAYS,   tgt: ST_DONE, alt: ST_DONE};
      ST_DONE: w = '{op: OP_DONE, cond: C_OUT,      tgt: ST_IDLE, alt: ST_IDLE};
      default: w = '{op: OP_IDLE, cond: C_ALWAYS,   tgt: ST_IDLE, alt: ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input logic [MODE_W-1:0] mode);
    step_t s;
    case (mode)
      MODE_SEARCH: s = ST_SCAN;
      MODE_CLEAR:  s = ST_CLR;
      default:     s = ST_DONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/fbba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fbba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/free_block_bitmap_allocator_unit.sv =====
// Top level of the free-block bitmap allocator: microcoded sequencer over a bitmap RAM.
//
//  channel | ports                               | beat
//  in      | in_valid in_stall in_mode           | one request
//          | in_block_number                     |
//  out     | out_valid out_stall out_found_index | one result
//          | out_status                          |
//  cfg     | cfg_wr_en cfg_wr_data               | block_count write
//
// Search: scans the bitmap one word per cycle, then takes up to 8 byte steps of the
// bit search. Mark occupied: read, modify-write, result. Format and the unused mode
// go straight to the result step. Format clears the per-word valid bits when it is
// accepted; reset needs no clearing pass. A stalled result holds in the output
// register while the next request is taken and run up to its own result step.
module free_block_bitmap_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fbba_pkg::MODE_W-1:0]  in_mode,
  input  logic [fbba_pkg::IDX_W-1:0]   in_block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fbba_pkg::IDX_W-1:0]   out_found_index,
  output logic [fbba_pkg::STAT_W-1:0]  out_status,
  input  logic                         cfg_wr_en,
  input  logic [fbba_pkg::BC_W-1:0]    cfg_wr_data
);

  fbba_pkg::step_t                   pc_r, pc_nxt;
  fbba_pkg::uword_t                  uw;
  logic [fbba_pkg::MAP_AW-1:0]       w_r, w_nxt;
  logic [fbba_pkg::CK_W-1:0]         k_r, k_nxt;
  logic [fbba_pkg::WB_LOG-1:0]       bit_r, bit_nxt;
  logic                              rng_ok_r, rng_ok_nxt;
  logic [fbba_pkg::WORD_BITS-1:0]    word_r, word_nxt;
  logic [fbba_pkg::IDX_W-1:0]        res_found_r, res_found_nxt;
  logic [fbba_pkg::STAT_W-1:0]       res_status_r, res_status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [fbba_pkg::IDX_W-1:0]        out_found_r, out_found_nxt;
  logic [fbba_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [fbba_pkg::BC_W-1:0]         bc_r, bc_nxt;
  logic [fbba_pkg::MAP_WORDS-1:0]    valid_r, valid_nxt;
  logic                              vld_q_r;

  logic [fbba_pkg::WORD_BITS-1:0]    ram_q;
  logic [fbba_pkg::WORD_BITS-1:0]    ram_word;
  logic [fbba_pkg::WORD_BITS-1:0]    ram_wdata;
  logic                              ram_we;
  logic [fbba_pkg::BC_W-1:0]         bc_word;
  logic [fbba_pkg::BC_W-1:0]         last_idx;
  logic [fbba_pkg::BC_W-1:0]         num_word;
  logic                              last;
  logic                              nz;
  logic [fbba_pkg::CB-1:0]           chunk;
  logic [fbba_pkg::CB_LOG-1:0]       pe;
  logic [fbba_pkg::SUM_W-1:0]        fsum;
  logic                              in_acc;
  logic                              out_free;
  logic                              hit;
  logic                              sel_alt;

  assign uw       = fbba_pkg::ucode_rom(pc_r);
  assign in_stall = (pc_r != fbba_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign bc_word  = fbba_pkg::BC_W'(bc_r >> fbba_pkg::WB_LOG);
  assign last_idx = (bc_word > fbba_pkg::LAST_CAP) ? fbba_pkg::LAST_CAP : bc_word;
  assign num_word = fbba_pkg::BC_W'(in_block_number >> fbba_pkg::WB_LOG);
  assign last     = (fbba_pkg::BC_W'(w_r) == last_idx);

  assign ram_word = vld_q_r ? ram_q : '1;
  assign nz       = |ram_word;
  assign chunk    = word_r[k_r*fbba_pkg::CB +: fbba_pkg::CB];

  always_comb begin
    pe = '0;
    for (int i = fbba_pkg::CB - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        pe = fbba_pkg::CB_LOG'(i);
      end
    end
  end

  assign fsum = (fbba_pkg::SUM_W'(w_r) << fbba_pkg::WB_LOG)
              + (fbba_pkg::SUM_W'(k_r) << fbba_pkg::CB_LOG)
              + fbba_pkg::SUM_W'(pe);

  assign ram_we    = (uw.op == fbba_pkg::OP_CLR) && rng_ok_r;
  assign ram_wdata = ram_word & ~(fbba_pkg::WORD_BITS'(1) << bit_r);

  fbba_ram #(
    .WIDTH (fbba_pkg::WORD_BITS),
    .DEPTH (fbba_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (ram_wdata),
    .raddr (w_nxt),
    .rdata (ram_q)
  );

  // sequencer: branch on the condition named by the control word
  always_comb begin
    hit     = 1'b0;
    sel_alt = 1'b0;
    case (uw.cond)
      fbba_pkg::C_DISPATCH: hit = in_acc;
      fbba_pkg::C_SCAN: begin
        hit     = nz || last;
        sel_alt = !nz;
      end
      fbba_pkg::C_BITS:   hit = |chunk;
      fbba_pkg::C_ALWAYS: hit = 1'b1;
      fbba_pkg::C_OUT:    hit = out_free;
      default:            hit = 1'b0;
    endcase
    if (!hit) begin
      pc_nxt = pc_r;
    end else if (uw.cond == fbba_pkg::C_DISPATCH) begin
      pc_nxt = fbba_pkg::dispatch(in_mode);
    end else if (sel_alt) begin
      pc_nxt = uw.alt;
    end else begin
      pc_nxt = uw.tgt;
    end
  end

  // datapath actions
  always_comb begin
    w_nxt          = w_r;
    k_nxt          = k_r;
    bit_nxt        = bit_r;
    rng_ok_nxt     = rng_ok_r;
    word_nxt       = word_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    valid_nxt      = valid_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    bc_nxt         = cfg_wr_en ? cfg_wr_data : bc_r;
    case (uw.op)
      fbba_pkg::OP_IDLE: begin
        if (in_acc) begin
          res_found_nxt  = '0;
          res_status_nxt = fbba_pkg::STAT_OK;
          w_nxt          = '0;
          case (in_mode)
            fbba_pkg::MODE_SEARCH: w_nxt = '0;
            fbba_pkg::MODE_CLEAR: begin
              w_nxt      = num_word[fbba_pkg::MAP_AW-1:0];
              bit_nxt    = in_block_number[fbba_pkg::WB_LOG-1:0];
              rng_ok_nxt = (num_word <= last_idx);
            end
            fbba_pkg::MODE_FORMAT: valid_nxt = '0;
            default: ;
          endcase
        end
      end
      fbba_pkg::OP_SCAN: begin
        if (nz) begin
          word_nxt = ram_word;
          k_nxt    = '0;
        end else if (last) begin
          res_status_nxt = fbba_pkg::STAT_FULL;
        end else begin
          w_nxt = w_r + fbba_pkg::MAP_AW'(1);
        end
      end
      fbba_pkg::OP_BITS: begin
        if (|chunk) begin
          res_found_nxt = fsum[fbba_pkg::IDX_W-1:0];
        end else begin
          k_nxt = k_r + fbba_pkg::CK_W'(1);
        end
      end
      fbba_pkg::OP_CLR: begin
        if (rng_ok_r) begin
          valid_nxt[w_r] = 1'b1;
        end else begin
          res_status_nxt = fbba_pkg::STAT_RANGE;
        end
      end
      fbba_pkg::OP_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= fbba_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      bc_r        <= fbba_pkg::BC_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      bc_r        <= bc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    k_r          <= k_nxt;
    bit_r        <= bit_nxt;
    rng_ok_r     <= rng_ok_nxt;
    word_r       <= word_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    vld_q_r      <= valid_r[w_nxt];
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_status_r;

endmodule

// ===== hw/rtl/fbba_checker.sv =====
// Port-level assertions for the free-block bitmap allocator, bound to the top level.
module fbba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [fbba_pkg::MODE_W-1:0]  in_mode,
  input logic [fbba_pkg::IDX_W-1:0]   in_block_number,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fbba_pkg::IDX_W-1:0]   out_found_index,
  input logic [fbba_pkg::STAT_W-1:0]  out_status,
  input logic                         cfg_wr_en,
  input logic [fbba_pkg::BC_W-1:0]    cfg_wr_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found_index) && $stable(out_status))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fbba_pkg::STAT_OK) |-> out_found_index == '0)
    else $error("failed result carries a non-zero index");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == fbba_pkg::STAT_OK) || (out_status == fbba_pkg::STAT_FULL)
                  || (out_status == fbba_pkg::STAT_RANGE))
    else $error("undefined status code");

endmodule

bind free_block_bitmap_allocator_unit fbba_checker u_fbba_checker (.*);
